// ----- rtl/fdq_pkg.sv -----
// fdq_pkg: shared types and constants for the dotted-quad finder
// no dependencies; imported by fdq_slot, fdq_select, first_dotted_quad_finder and the bench
package fdq_pkg;

  localparam int unsigned WINDOW_CHARS_DEF = 15;
  localparam int unsigned MIN_CHARS        = 7;
  localparam int unsigned PART_MAX         = 255;
  localparam int unsigned RADIX            = 10;
  localparam int unsigned LEN_W            = 4;
  localparam int unsigned VAL_W            = 12;

  localparam logic [7:0] DOT_CHAR   = 8'h2E;
  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] DIGIT_NINE = 8'h39;

  localparam logic [2:0] QUAD_DOTS   = 3'd3;
  localparam logic [2:0] FAILED_DOTS = 3'd7;

  typedef struct packed {
    logic [2:0]  dots;
    logic [7:0]  part;
    logic [23:0] prior;
  } win_t;

  typedef struct packed {
    logic       is_num;
    logic       is_dot;
    logic       is_end;
    logic [3:0] digit;
  } chr_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] addr;
  } hit_t;

endpackage

// ----- rtl/fdq_slot.sv -----
// fdq_slot: next-state and close check for one candidate window
// depends on fdq_pkg; one instance per position of the window shift line
module fdq_slot import fdq_pkg::*; #(
  parameter int unsigned WINDOW_CHARS = WINDOW_CHARS_DEF,
  parameter int unsigned POS          = 0
) (
  input  logic open_i,
  input  win_t win_i,
  input  chr_t chr_i,
  output logic open_o,
  output win_t win_o,
  output hit_t hit_o
);

  localparam logic [LEN_W-1:0] LenCur = LEN_W'(POS + 1);
  localparam logic [LEN_W-1:0] LenNew = LEN_W'(POS + 2);
  localparam logic             AtLimit = (POS + 2) >= WINDOW_CHARS;

  logic             taken;
  logic             closing;
  logic [VAL_W-1:0] val;
  logic [LEN_W-1:0] len;
  logic [31:0]      addr;

  assign taken = chr_i.is_num | chr_i.is_dot;
  assign val   = VAL_W'(win_i.part) * VAL_W'(RADIX) + VAL_W'(chr_i.digit);

  always_comb begin
    win_o = win_i;
    if (taken && (win_i.dots <= QUAD_DOTS)) begin
      if (chr_i.is_dot) begin
        if (win_i.dots == QUAD_DOTS) begin
          win_o.dots = FAILED_DOTS;
        end else begin
          win_o.prior = {win_i.prior[15:0], win_i.part};
          win_o.part  = '0;
          win_o.dots  = win_i.dots + 3'd1;
        end
      end else if (val > VAL_W'(PART_MAX)) begin
        win_o.dots = FAILED_DOTS;
      end else begin
        win_o.part = val[7:0];
      end
    end
  end

  assign len     = taken ? LenNew : LenCur;
  assign closing = !taken || chr_i.is_end || AtLimit;
  assign addr    = {win_o.prior, win_o.part};
  assign open_o  = open_i && !closing;

  assign hit_o.hit  = open_i && closing && (len >= LEN_W'(MIN_CHARS)) &&
                      (win_o.dots == QUAD_DOTS) && (addr != '0);
  assign hit_o.addr = addr;

endmodule

// ----- rtl/fdq_select.sv -----
// fdq_select: picks the longest valid closing window
// depends on fdq_pkg; the oldest position wins
module fdq_select import fdq_pkg::*; #(
  parameter int unsigned SLOTS = WINDOW_CHARS_DEF - 1
) (
  input  hit_t hit_i [SLOTS],
  output hit_t best_o
);

  always_comb begin
    best_o = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit_i[i].hit) begin
        best_o = hit_i[i];
      end
    end
  end

endmodule

// ----- rtl/first_dotted_quad_finder.sv -----
// first_dotted_quad_finder: streaming search for the first dotted-decimal address
// depends on fdq_pkg, fdq_slot, fdq_select
//
//   channel  valid       stall        payload
//   in       in_valid_i  in_stall_o   text_byte_i, buffer_end_i
//   out      out_valid_o out_stall_i  found_o, address_o
//
// one byte per cycle unless in_stall_o holds the sender off; a request passes through
// the input register and then the result register before its result leaves
// reset closes all windows and clears the held answer and both valid flags
// only a last byte waits on a stalled result register; other bytes flow on
// the window shift line holds WINDOW_CHARS-1 positions, one per window age
module first_dotted_quad_finder import fdq_pkg::*; #(
  parameter int unsigned WINDOW_CHARS = WINDOW_CHARS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        buffer_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [31:0] address_o
);

  localparam int unsigned SLOTS = WINDOW_CHARS - 1;

  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        end_q;
  logic        advance;
  chr_t        chr;

  logic [SLOTS-1:0] open_q, open_d;
  win_t             win_q [SLOTS];
  win_t             win_d [SLOTS];
  logic [SLOTS-1:0] slot_open;
  win_t             slot_win [SLOTS];
  hit_t             slot_hit [SLOTS];
  hit_t             best;

  logic        have_q, have_d;
  logic [31:0] answer_q, answer_d;
  logic        out_valid_q;
  logic        found_q;
  logic [31:0] address_q;

  // input register
  assign advance    = in_valid_q && (!end_q || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= text_byte_i;
      end_q  <= buffer_end_i;
    end
  end

  // character class
  always_comb begin
    chr.is_num = byte_q inside {[DIGIT_ZERO:DIGIT_NINE]};
    chr.is_dot = byte_q == DOT_CHAR;
    chr.is_end = end_q;
    chr.digit  = chr.is_num ? 4'(byte_q - DIGIT_ZERO) : 4'd0;
  end

  // window shift line
  for (genvar g = 0; g < SLOTS; g++) begin : g_slot
    fdq_slot #(
      .WINDOW_CHARS(WINDOW_CHARS),
      .POS         (g)
    ) u_slot (
      .open_i(open_q[g]),
      .win_i (win_q[g]),
      .chr_i (chr),
      .open_o(slot_open[g]),
      .win_o (slot_win[g]),
      .hit_o (slot_hit[g])
    );
  end

  fdq_select #(
    .SLOTS(SLOTS)
  ) u_select (
    .hit_i (slot_hit),
    .best_o(best)
  );

  always_comb begin
    open_d = open_q;
    win_d  = win_q;
    if (advance) begin
      if (chr.is_end || !(chr.is_num || chr.is_dot)) begin
        open_d = '0;
      end else begin
        open_d[0]     = chr.is_num;
        win_d[0].dots  = '0;
        win_d[0].part  = 8'(chr.digit);
        win_d[0].prior = '0;
        for (int i = 1; i < SLOTS; i++) begin
          open_d[i] = slot_open[i-1];
          win_d[i]  = slot_win[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  // held answer
  always_comb begin
    have_d   = have_q;
    answer_d = answer_q;
    if (advance) begin
      if (end_q) begin
        have_d   = 1'b0;
        answer_d = '0;
      end else if (best.hit && !have_q) begin
        have_d   = 1'b1;
        answer_d = best.addr;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q   <= 1'b0;
      answer_q <= '0;
    end else begin
      have_q   <= have_d;
      answer_q <= answer_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && end_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && end_q) begin
      found_q   <= have_q || best.hit;
      address_q <= have_q ? answer_q : (best.hit ? best.addr : '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign address_o   = address_q;

endmodule

// ----- rtl/fdq_checker.sv -----
// fdq_checker: port-level checks for the dotted-quad finder
// no package use; bound to first_dotted_quad_finder below
module fdq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        buffer_end_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        found_o,
  input logic [31:0] address_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(found_o) && $stable(address_o))
    else $error("result changed while stalled");

  // not-found result carries a zero address
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> address_o == 32'd0)
    else $error("not-found result with nonzero address");

  // found result is never 0.0.0.0
  a_hit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> address_o != 32'd0)
    else $error("found result with zero address");

  // a fresh result traces back to an accepted last byte
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && buffer_end_i, 2))
    else $error("result without a last byte");

endmodule

bind first_dotted_quad_finder fdq_checker u_fdq_checker (.*);

// ----- sim/first_dotted_quad_finder_tb.sv -----
// first_dotted_quad_finder_tb: self-checking bench for the dotted-quad finder
// feeds byte buffers under random idling and checks every result against a model or a typed row
// depends on fdq_pkg and first_dotted_quad_finder
module first_dotted_quad_finder_tb;
  import fdq_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1100;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned PRESSURE_AT  = 15;
  localparam int unsigned DRAIN_AT     = 40;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int          ROWS         = 6;

  typedef logic [7:0] byte_queue_t [$];

  typedef struct packed {
    logic typed;
    hit_t res;
  } answer_t;

  logic        clk          = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic [7:0]  text_byte_i  = 8'h00;
  logic        buffer_end_i = 1'b0;
  logic        out_stall_i  = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        found_o;
  logic [31:0] address_o;

  logic calm_phase = 1'b0;
  logic hold_phase = 1'b0;
  logic hold_done  = 1'b0;

  logic        win_open [WINDOW_CHARS_DEF];
  logic [3:0]  win_len  [WINDOW_CHARS_DEF];
  win_t        win      [WINDOW_CHARS_DEF];
  logic        held;
  logic [31:0] held_addr;

  hit_t    pending_hits  [$];
  answer_t typed_answers [$];

  int bytes_sent      = 0;
  int buffers_sent    = 0;
  int results_checked = 0;
  int found_count     = 0;
  int mismatches      = 0;

  string row_text [ROWS] = '{
    "7", "255.255.255.255", "0.0.0.0", "1.0.0.1.5", "1.1.1.256", "8.8.8.8\3109"
  };
  logic  row_typed [ROWS] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
  hit_t  row_hit   [ROWS] = '{
    '{1'b0, 32'h0}, '{1'b1, 32'hffff_ffff}, '{1'b0, 32'h0},
    '{1'b0, 32'h0}, '{1'b0, 32'h0}, '{1'b0, 32'h0}
  };

  first_dotted_quad_finder dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .text_byte_i  (text_byte_i),
    .buffer_end_i (buffer_end_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .found_o      (found_o),
    .address_o    (address_o)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void clear_windows();
    for (int s = 0; s < WINDOW_CHARS_DEF; s++) begin
      win_open[s] = 1'b0;
      win_len[s]  = '0;
      win[s]      = '0;
    end
    held      = 1'b0;
    held_addr = '0;
  endfunction

  function automatic void track_windows(input logic [7:0] ch, input logic last,
                                        output logic done, output hit_t res);
    logic        is_num, is_dot, closing, placed;
    int unsigned dval, v, best_len;
    logic [31:0] best_addr, addr;
    is_num    = (ch >= DIGIT_ZERO) && (ch <= DIGIT_NINE);
    is_dot    = (ch == DOT_CHAR);
    dval      = is_num ? int'(ch - DIGIT_ZERO) : 0;
    best_len  = 0;
    best_addr = '0;
    for (int s = 0; s < WINDOW_CHARS_DEF; s++) begin
      if (win_open[s]) begin
        closing = !(is_num || is_dot);
        if (!closing) begin
          if (win[s].dots <= QUAD_DOTS) begin
            if (is_dot) begin
              if (win[s].dots == QUAD_DOTS) begin
                win[s].dots = FAILED_DOTS;
              end else begin
                win[s].prior = {win[s].prior[15:0], win[s].part};
                win[s].part  = '0;
                win[s].dots  = win[s].dots + 3'd1;
              end
            end else begin
              v = int'(win[s].part) * RADIX + dval;
              if (v > PART_MAX) begin
                win[s].dots = FAILED_DOTS;
              end else begin
                win[s].part = 8'(v);
              end
            end
          end
          win_len[s] = win_len[s] + 4'd1;
          closing    = (win_len[s] >= WINDOW_CHARS_DEF) || last;
        end
        if (closing) begin
          addr        = {win[s].prior, win[s].part};
          win_open[s] = 1'b0;
          if (win_len[s] >= MIN_CHARS && win[s].dots == QUAD_DOTS && addr != '0 &&
              win_len[s] > best_len) begin
            best_len  = win_len[s];
            best_addr = addr;
          end
        end
      end
    end
    if (is_num && !last) begin
      placed = 1'b0;
      for (int s = 0; s < WINDOW_CHARS_DEF; s++) begin
        if (!placed && !win_open[s]) begin
          win_open[s]  = 1'b1;
          win_len[s]   = 4'd1;
          win[s].dots  = '0;
          win[s].part  = 8'(dval);
          win[s].prior = '0;
          placed       = 1'b1;
        end
      end
    end
    if (best_len != 0 && !held) begin
      held      = 1'b1;
      held_addr = best_addr;
    end
    done     = last;
    res.hit  = held;
    res.addr = held ? held_addr : '0;
    if (last) clear_windows();
  endfunction

  function automatic int unsigned gap_len(input logic calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic byte_queue_t make_buffer();
    byte_queue_t q;
    int unsigned parts, v;
    string       num;
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, 9))
        0, 1: repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(0, 255)));
        2: repeat ($urandom_range(1, 8)) q.push_back(DIGIT_ZERO + 8'($urandom_range(0, 9)));
        3: repeat ($urandom_range(1, 4)) q.push_back($urandom_range(0, 1) ? DOT_CHAR : 8'h20);
        default: begin
          parts = ($urandom_range(0, 9) < 7) ? 4 : $urandom_range(2, 6);
          for (int p = 0; p < parts; p++) begin
            if (p != 0) q.push_back(DOT_CHAR);
            if ($urandom_range(0, 19) != 0) begin
              if ($urandom_range(0, 19) == 0) begin
                v = $urandom_range(256, 999);
              end else if ($urandom_range(0, 3) == 0) begin
                v = $urandom_range(0, 9);
              end else begin
                v = $urandom_range(0, 255);
              end
              num = $sformatf("%0d", v);
              if ($urandom_range(0, 9) == 0) q.push_back(DIGIT_ZERO);
              for (int i = 0; i < num.len(); i++) q.push_back(num[i]);
            end
          end
        end
      endcase
    end
    if (q.size() == 0 || $urandom_range(0, 3) == 0) q.push_back(8'($urandom_range(0, 255)));
    return q;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h, want %h", what, got, want);
    mismatches++;
  endtask

  task automatic offer_byte(input logic [7:0] ch, input logic last);
    in_valid_i   <= 1'b1;
    text_byte_i  <= ch;
    buffer_end_i <= last;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic pause_sender(input int unsigned cycles);
    if (cycles != 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic send_buffer(input byte_queue_t text, input logic calm);
    for (int i = 0; i < text.size(); i++) begin
      offer_byte(text[i], i == text.size() - 1);
      pause_sender(gap_len(calm));
    end
    buffers_sent++;
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk);
    while (pending_hits.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : monitor
    hit_t    want, got;
    answer_t row;
    logic    done;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_hits.size() == 0) begin
          report_mismatch("unrequested result", {31'b0, found_o}, address_o);
        end else begin
          want = pending_hits.pop_front();
          if (found_o !== want.hit) report_mismatch("found", {31'b0, found_o}, {31'b0, want.hit});
          if (address_o !== want.addr) report_mismatch("address", address_o, want.addr);
          results_checked++;
          if (want.hit) found_count++;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        track_windows(text_byte_i, buffer_end_i, done, got);
        if (done) begin
          if (typed_answers.size() != 0) begin
            row = typed_answers.pop_front();
            if (row.typed) got = row.res;
          end
          pending_hits.push_back(got);
        end
      end
    end
  end

  initial begin : receiver
    int unsigned n;
    forever begin
      @(posedge clk);
      if (hold_phase && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall_i <= 1'b0;
        hold_done   <= 1'b1;
      end else begin
        n = gap_len(calm_phase);
        if (n != 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    byte_queue_t text;
    int          target;
    logic        calm;
    clear_windows();
    repeat (8) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < ROWS; r++) begin
      text.delete();
      for (int i = 0; i < row_text[r].len(); i++) text.push_back(row_text[r][i]);
      typed_answers.push_back('{row_typed[r], row_hit[r]});
      send_buffer(text, 1'b0);
    end

    target = bytes_sent + RANDOM_ITEMS;
    while (bytes_sent < target) begin
      calm = (buffers_sent % 12) < 2;
      calm_phase <= calm;
      if (buffers_sent == PRESSURE_AT) begin
        // results back up while the receiver holds off
        hold_phase <= 1'b1;
        while (!hold_done) begin
          text.delete();
          text.push_back(8'($urandom_range(0, 255)));
          send_buffer(text, 1'b1);
        end
        hold_phase <= 1'b0;
        wait_for_results();
      end
      if (buffers_sent == DRAIN_AT) wait_for_results();
      send_buffer(make_buffer(), calm);
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d bytes in %0d buffers, random idling on both sides", bytes_sent,
             buffers_sent);
    $display("checked %0d results, %0d carrying an address", results_checked, found_count);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * 12);
    $display("status: fail");
    $finish;
  end

endmodule

// ----- first_dotted_quad_finder.f -----
rtl/fdq_pkg.sv
rtl/fdq_slot.sv
rtl/fdq_select.sv
rtl/first_dotted_quad_finder.sv
rtl/fdq_checker.sv
sim/first_dotted_quad_finder_tb.sv
